// File: rtl/core/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    localparam int NUM_BLOCKS = 64;
    localparam int BLK_W      = 6;   // block number field width
    localparam int CNT_W      = 7;   // block count field width
    localparam int FREE_W     = $clog2(NUM_BLOCKS + 1);
    localparam int SUM_W      = CNT_W + 1;

    localparam logic OP_CONTIG  = 1'b0;
    localparam logic OP_SCATTER = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_HDR_TAKEN = 2'd1;
    localparam logic [1:0] ST_NO_FREE   = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic             op;
        logic [BLK_W-1:0] start_block;
        logic [CNT_W-1:0] block_count;
        logic             range_bad;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_q_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CHECK,
        BK_CONTIG,
        BK_SCAN
    } bk_state_t;

endpackage

// File: rtl/core/block_bitmap_allocator_top.sv
`timescale 1ns / 1ps

// Block bitmap allocator: one used bit per block, all free after reset.
// Input words (s_axis) carry a request: tuser is the op (0 contiguous range,
// 1 scattered with header), tdata holds the start/header block and count.
// Output words (m_axis) carry one granted block each, ascending, with
// tlast on the final word of the request. A failed request gives one word
// with tuser low, block index 0, the status code and tlast high.
// A front end checks bounds and queues up to two requests; the back end
// owns the bitmap and works through one request at a time.
// The back end pops a request into its command register, checks it, then
// answers a failed or empty request from the check state; a contiguous run
// follows it, and a scattered request's first word comes when the scan reaches its lowest block.
// Contiguous run: one word per cycle while the output is not stalled. Scattered
// request: the back end walks the bitmap one block per cycle, likewise unless
// stalled, from block 0 until its last block is granted; that single-block scan sets its rate.
// Reset clears the bitmap at once; no clearing pass is needed.
// When m_axis_tready is low the back end holds its word and stops; the
// queue keeps taking requests until it is full.
module block_bitmap_allocator_top
    import bba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // start_block[5:0], block_count[12:6], zero pad
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // block_index[5:0], status[7:6]
    output logic        m_axis_tuser,   // block_valid
    output logic        m_axis_tlast
);

    cmd_q_t           q_head;
    logic             q_pop;
    logic [BLK_W-1:0] block_index;
    logic [1:0]       status;

    bba_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .op          (s_axis_tuser),
        .start_block (s_axis_tdata[BLK_W-1:0]),
        .block_count (s_axis_tdata[BLK_W+CNT_W-1:BLK_W]),
        .q_head      (q_head),
        .q_pop       (q_pop)
    );

    bba_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .block_valid (m_axis_tuser),
        .block_index (block_index),
        .status      (status),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {status, block_index};

endmodule

// File: rtl/core/bba_front.sv
`timescale 1ns / 1ps

module bba_front
    import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             op,
    input  logic [BLK_W-1:0] start_block,
    input  logic [CNT_W-1:0] block_count,
    output cmd_q_t           q_head,
    input  logic             q_pop
);

    localparam int QDEPTH = 2;

    cmd_t            entry_reg [QDEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;
    cmd_t            cmd_in;
    logic [SUM_W-1:0] range_end;
    logic            start_bad;
    logic            push;
    logic            pop;

    // bounds are checked here, the bitmap checks happen in the back end
    always_comb
    begin
        range_end = SUM_W'(start_block) + SUM_W'(block_count);
        start_bad = SUM_W'(start_block) >= SUM_W'(NUM_BLOCKS);
        cmd_in.op          = op;
        cmd_in.start_block = start_block;
        cmd_in.block_count = block_count;
        if (op == OP_CONTIG)
        begin
            cmd_in.range_bad = start_bad || (range_end > SUM_W'(NUM_BLOCKS));
        end
        else
        begin
            cmd_in.range_bad = start_bad;
        end
    end

    assign in_ready     = (fill_reg != 2'(QDEPTH));
    assign push         = in_valid && in_ready;
    assign pop          = q_pop && (fill_reg != 2'd0);
    assign q_head.valid = (fill_reg != 2'd0);
    assign q_head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: rtl/core/bba_back.sv
`timescale 1ns / 1ps

module bba_back
    import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_q_t           q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             block_valid,
    output logic [BLK_W-1:0] block_index,
    output logic [1:0]       status,
    output logic             last
);

    bk_state_t           state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [NUM_BLOCKS-1:0] used_reg, used_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic [BLK_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]    data_left_reg, data_left_next;
    logic [CNT_W-1:0]    left_reg, left_next;

    logic                ov_reg, ov_next;
    logic                ob_valid_reg, ob_valid_next;
    logic [BLK_W-1:0]    ob_index_reg, ob_index_next;
    logic [1:0]          ob_status_reg, ob_status_next;
    logic                ob_last_reg, ob_last_next;

    logic                can_push;
    logic [SUM_W-1:0]    rng_lo, rng_hi;
    logic                range_busy;
    logic                hdr_used;
    logic                short_free;
    logic                check_fail;
    logic                zero_len;
    logic [BLK_W-1:0]    end_idx;
    logic                contig_last;
    logic                scan_take;
    logic                scan_done;
    logic                emit;
    logic [BLK_W-1:0]    emit_idx;
    logic [1:0]          emit_status;
    logic                emit_bvalid;
    logic                emit_last;
    logic                mark_en;

    assign can_push = !ov_reg || out_ready;

    // checks on the current command
    always_comb
    begin
        rng_lo     = SUM_W'(cmd_reg.start_block);
        rng_hi     = SUM_W'(cmd_reg.start_block) + SUM_W'(cmd_reg.block_count);
        range_busy = 1'b0;
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            if (used_reg[i] && (SUM_W'(i) >= rng_lo) && (SUM_W'(i) < rng_hi))
            begin
                range_busy = 1'b1;
            end
        end
        hdr_used   = used_reg[cmd_reg.start_block];
        // header is free, so free_reg - 1 blocks remain for data
        short_free = (SUM_W'(cmd_reg.block_count) + SUM_W'(1)) > SUM_W'(free_reg);
        zero_len   = (cmd_reg.block_count == '0);
        if (cmd_reg.range_bad)
        begin
            check_fail = 1'b1;
        end
        else if (cmd_reg.op == OP_CONTIG)
        begin
            check_fail = range_busy;
        end
        else
        begin
            check_fail = hdr_used || short_free;
        end
        end_idx     = cmd_reg.start_block + cmd_reg.block_count[BLK_W-1:0] - 1'b1;
        contig_last = (cur_reg == end_idx);
        scan_take   = (cur_reg == cmd_reg.start_block) ||
                      (!used_reg[cur_reg] && (data_left_reg != '0));
        scan_done   = scan_take && (left_reg == CNT_W'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_head.valid)
                begin
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                if (can_push)
                begin
                    if (check_fail)
                    begin
                        state_next = BK_IDLE;
                    end
                    else if (cmd_reg.op == OP_CONTIG)
                    begin
                        state_next = zero_len ? BK_IDLE : BK_CONTIG;
                    end
                    else
                    begin
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_CONTIG:
            begin
                if (can_push && contig_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_SCAN:
            begin
                if (can_push && scan_done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop          = 1'b0;
        cmd_next       = cmd_reg;
        cur_next       = cur_reg;
        data_left_next = data_left_reg;
        left_next      = left_reg;
        emit           = 1'b0;
        emit_idx       = '0;
        emit_status    = ST_OK;
        emit_bvalid    = 1'b0;
        emit_last      = 1'b1;
        mark_en        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head.cmd;
                end
            end
            BK_CHECK:
            begin
                if (can_push)
                begin
                    cur_next       = (cmd_reg.op == OP_CONTIG) ? cmd_reg.start_block : '0;
                    data_left_next = cmd_reg.block_count;
                    left_next      = cmd_reg.block_count + 1'b1;
                    if (cmd_reg.range_bad)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_RANGE;
                    end
                    else if (cmd_reg.op == OP_CONTIG)
                    begin
                        if (range_busy)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_NO_FREE;
                        end
                        else if (zero_len)
                        begin
                            emit = 1'b1;
                        end
                    end
                    else if (hdr_used)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_HDR_TAKEN;
                    end
                    else if (short_free)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_NO_FREE;
                    end
                end
            end
            BK_CONTIG:
            begin
                if (can_push)
                begin
                    emit        = 1'b1;
                    emit_bvalid = 1'b1;
                    emit_idx    = cur_reg;
                    emit_last   = contig_last;
                    mark_en     = 1'b1;
                    cur_next    = cur_reg + 1'b1;
                end
            end
            BK_SCAN:
            begin
                if (can_push)
                begin
                    cur_next = cur_reg + 1'b1;
                    if (scan_take)
                    begin
                        emit        = 1'b1;
                        emit_bvalid = 1'b1;
                        emit_idx    = cur_reg;
                        emit_last   = scan_done;
                        mark_en     = 1'b1;
                        left_next   = left_reg - 1'b1;
                        if (cur_reg != cmd_reg.start_block)
                        begin
                            data_left_next = data_left_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        free_next = free_reg;
        if (mark_en)
        begin
            used_next[emit_idx] = 1'b1;
            free_next           = free_reg - 1'b1;
        end
    end

    // output register: loads while empty or being drained
    always_comb
    begin
        ov_next        = ov_reg;
        ob_valid_next  = ob_valid_reg;
        ob_index_next  = ob_index_reg;
        ob_status_next = ob_status_reg;
        ob_last_next   = ob_last_reg;
        if (emit)
        begin
            ov_next        = 1'b1;
            ob_valid_next  = emit_bvalid;
            ob_index_next  = emit_idx;
            ob_status_next = emit_status;
            ob_last_next   = emit_last;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            used_reg  <= '0;
            free_reg  <= FREE_W'(NUM_BLOCKS);
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            free_reg  <= free_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        cur_reg       <= cur_next;
        data_left_reg <= data_left_next;
        left_reg      <= left_next;
        ob_valid_reg  <= ob_valid_next;
        ob_index_reg  <= ob_index_next;
        ob_status_reg <= ob_status_next;
        ob_last_reg   <= ob_last_next;
    end

    assign out_valid   = ov_reg;
    assign block_valid = ob_valid_reg;
    assign block_index = ob_index_reg;
    assign status      = ob_status_reg;
    assign last        = ob_last_reg;

endmodule
